// ===== design/djd_pkg.sv =====
// ---------------------------------------------------------------------------
// djd_pkg: shared constants and functions for the stepper jog driver
// Counter widths, register indexes, reset values and the half-step table.
// ---------------------------------------------------------------------------
package djd_pkg;

  localparam int COUNT_W    = 11;
  localparam int REG_W      = 10;
  localparam int PHASE_W    = 3;
  localparam int COIL_W     = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd1;

  localparam logic [REG_W-1:0] DEBOUNCE_RESET      = 10'd30;
  localparam logic [REG_W-1:0] STEP_INTERVAL_RESET = 10'd2;

  // Saturating increment shared by all elapsed counters
  function automatic logic [COUNT_W-1:0] count_bump(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  // Half-step coil drive, bit0 is coil one
  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/debounced_stepper_jog_driver.sv =====
// ---------------------------------------------------------------------------
// debounced_stepper_jog_driver: debounced two-button half-step jog sequencer
// One tick item in, one coil drive result out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one millisecond tick: raw
//   forward and back button levels (active low) and the motor enable.
//   Output channel (out_valid / out_stall) returns one result per tick: coil
//   pattern, phase index, step flag and the two debounced button states.
//   Configuration channel (cfg_valid / cfg_ready, always ready) sets the
//   debounce time (index 0) and the minimum step interval (index 1); writes
//   to other indexes are dropped. Write only while the block is idle.
//   The result of a tick sits in the output register the cycle after its
//   transfer. Throughput is one tick per cycle while the receiver does not
//   stall, set by the single output register, which is refilled in the same
//   cycle it is taken. While the receiver stalls a full output register,
//   in_stall is raised and the held result stays put.
//   Reset clears the counters and phase, marks both buttons released and
//   loads the default registers (debounce 30, interval 2); no result pending.
// ---------------------------------------------------------------------------
module debounced_stepper_jog_driver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          fwd_level,
  input  logic                          back_level,
  input  logic                          motor_enable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [djd_pkg::COIL_W-1:0]    coil_pattern,
  output logic [djd_pkg::PHASE_W-1:0]   phase_index,
  output logic                          stepped,
  output logic                          fwd_pressed,
  output logic                          back_pressed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [djd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [djd_pkg::REG_W-1:0]     cfg_data
);
  import djd_pkg::*;

  logic [REG_W-1:0]   debounce_ticks;
  logic [REG_W-1:0]   step_interval_ticks;
  logic [COUNT_W-1:0] since_step_count;
  logic [COUNT_W-1:0] since_step_count_next;
  logic [COUNT_W-1:0] elapsed;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic               fwd_now;
  logic               back_now;
  logic               step_take;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= DEBOUNCE_RESET;
      step_interval_ticks <= STEP_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:      debounce_ticks      <= cfg_data;
        REG_STEP_INTERVAL: step_interval_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  djd_debounce u_fwd (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .level          (fwd_level),
    .debounce_ticks (debounce_ticks),
    .pressed        (fwd_now)
  );

  djd_debounce u_back (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .level          (back_level),
    .debounce_ticks (debounce_ticks),
    .pressed        (back_now)
  );

  assign elapsed   = count_bump(since_step_count);
  assign step_take = motor_enable && (fwd_now != back_now)
                     && (elapsed >= {1'b0, step_interval_ticks});

  always_comb begin
    since_step_count_next = elapsed;
    phase_next            = phase;
    if (step_take) begin
      since_step_count_next = '0;
      phase_next            = fwd_now ? phase + 1'b1 : phase - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_step_count <= '0;
      phase            <= '0;
    end else if (accept) begin
      since_step_count <= since_step_count_next;
      phase            <= phase_next;
    end
  end

  // Output register: load on transfer in, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coil_pattern <= coil_of(phase_next);
      phase_index  <= phase_next;
      stepped      <= step_take;
      fwd_pressed  <= fwd_now;
      back_pressed <= back_now;
    end
  end

`ifndef SYNTHESIS
  a_result_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (phase_index == phase))
    else $error("result phase does not match phase state");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    accept && !step_take |=> phase == $past(phase))
    else $error("phase moved on a tick without a step");

  a_coil_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coil_pattern == coil_of(phase_index))
    else $error("coil pattern inconsistent with phase index");
`endif

endmodule

// ===== design/djd_debounce.sv =====
// ---------------------------------------------------------------------------
// djd_debounce: single push-button debouncer
// Tracks the last raw level and a saturating elapsed count; the press state
// for the current tick is presented combinationally from the updated count.
// ---------------------------------------------------------------------------
module djd_debounce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      level,
  input  logic [djd_pkg::REG_W-1:0] debounce_ticks,
  output logic                      pressed
);
  import djd_pkg::*;

  logic               last_level;
  logic [COUNT_W-1:0] stable_count;
  logic [COUNT_W-1:0] stable_count_next;

  // Restart the count on any level change, otherwise advance and saturate
  always_comb begin
    if (level != last_level) begin
      stable_count_next = '0;
    end else begin
      stable_count_next = count_bump(stable_count);
    end
  end

  assign pressed = (stable_count_next > {1'b0, debounce_ticks}) && !level;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b1;
      stable_count <= '0;
    end else if (advance) begin
      last_level   <= level;
      stable_count <= stable_count_next;
    end
  end

endmodule

// ===== tb/sv/tb_debounced_stepper_jog_driver.sv =====
// ---------------------------------------------------------------------------
// tb_debounced_stepper_jog_driver: self-checking bench for the jog driver
// Drives tick transfers with random sender gaps and receiver stalls, tracks
// debounce, step spacing and phase in a scoreboard and checks every result.
// ---------------------------------------------------------------------------
module tb_debounced_stepper_jog_driver;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int PRINT_CAP       = 60;

  localparam logic [djd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [djd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [djd_pkg::REG_W-1:0]   REG_TOP  = 10'h3FF;
  localparam logic [djd_pkg::COUNT_W-1:0] AGE_CEIL = 11'h7FF;
  // half-step coil patterns, phase 0 in the low nibble
  localparam logic [31:0] HALF_STEP_COILS = 32'h98C46231;

  typedef struct packed {
    logic [djd_pkg::COIL_W-1:0]  coil;
    logic [djd_pkg::PHASE_W-1:0] phase;
    logic                        stepped;
    logic                        fwd;
    logic                        back;
  } drive_t;

  class jog_tracker;
    logic [djd_pkg::REG_W-1:0]   debounce_lim;
    logic [djd_pkg::REG_W-1:0]   interval_lim;
    logic                        fwd_prev;
    logic                        back_prev;
    logic [djd_pkg::COUNT_W-1:0] fwd_age;
    logic [djd_pkg::COUNT_W-1:0] back_age;
    logic [djd_pkg::COUNT_W-1:0] step_age;
    logic [djd_pkg::PHASE_W-1:0] phase;
    drive_t                      pending_drive[$];
    int                          errors;
    int                          results_seen;

    function new();
      debounce_lim = djd_pkg::DEBOUNCE_RESET;
      interval_lim = djd_pkg::STEP_INTERVAL_RESET;
      fwd_prev     = 1'b1;
      back_prev    = 1'b1;
      fwd_age      = '0;
      back_age     = '0;
      step_age     = '0;
      phase        = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [djd_pkg::CFG_IDX_W-1:0] idx,
                            logic [djd_pkg::REG_W-1:0] val);
      if (idx == djd_pkg::REG_DEBOUNCE) begin
        debounce_lim = val;
      end else if (idx == djd_pkg::REG_STEP_INTERVAL) begin
        interval_lim = val;
      end
    endfunction

    // restart on a level change, otherwise advance and hold at the ceiling
    function logic [djd_pkg::COUNT_W-1:0] aged(logic lvl, logic prev,
                                               logic [djd_pkg::COUNT_W-1:0] age);
      if (lvl != prev) return '0;
      return (age == AGE_CEIL) ? age : age + 11'd1;
    endfunction

    function void take_tick(logic fl, logic bl, logic en);
      drive_t                      d;
      logic [djd_pkg::COUNT_W-1:0] elapsed;
      fwd_age   = aged(fl, fwd_prev, fwd_age);
      fwd_prev  = fl;
      back_age  = aged(bl, back_prev, back_age);
      back_prev = bl;
      d.fwd     = !fl && (fwd_age > {1'b0, debounce_lim});
      d.back    = !bl && (back_age > {1'b0, debounce_lim});
      elapsed   = (step_age == AGE_CEIL) ? step_age : step_age + 11'd1;
      d.stepped = 1'b0;
      if (en && (d.fwd != d.back) && (elapsed >= {1'b0, interval_lim})) begin
        phase     = d.fwd ? phase + 3'd1 : phase - 3'd1;
        elapsed   = '0;
        d.stepped = 1'b1;
      end
      step_age = elapsed;
      d.phase  = phase;
      d.coil   = HALF_STEP_COILS[{phase, 2'b00} +: 4];
      pending_drive.push_back(d);
    endfunction

    function int outstanding();
      return pending_drive.size();
    endfunction

    task report(string what, int got, int want);
      if (errors < PRINT_CAP) begin
        $display("mismatch on result %0d: %s got %0d want %0d",
                 results_seen, what, got, want);
      end
      errors++;
    endtask

    task match_result(drive_t got);
      drive_t want;
      results_seen++;
      if (pending_drive.size() == 0) begin
        report("unrequested result, coil_pattern", int'(got.coil), 0);
        return;
      end
      want = pending_drive.pop_front();
      if (got.coil != want.coil)
        report("coil_pattern", int'(got.coil), int'(want.coil));
      if (got.phase != want.phase)
        report("phase_index", int'(got.phase), int'(want.phase));
      if (got.stepped != want.stepped)
        report("stepped", int'(got.stepped), int'(want.stepped));
      if (got.fwd != want.fwd)
        report("fwd_pressed", int'(got.fwd), int'(want.fwd));
      if (got.back != want.back)
        report("back_pressed", int'(got.back), int'(want.back));
    endtask
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          fwd_level = 1'b1;
  logic                          back_level = 1'b1;
  logic                          motor_enable = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [djd_pkg::COIL_W-1:0]    coil_pattern;
  logic [djd_pkg::PHASE_W-1:0]   phase_index;
  logic                          stepped;
  logic                          fwd_pressed;
  logic                          back_pressed;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [djd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [djd_pkg::REG_W-1:0]     cfg_data = '0;

  jog_tracker tracker;
  bit         tx_bursty = 1'b0;
  bit         rx_bursty = 1'b0;
  bit         no_idle = 1'b0;
  bit         hold_off_req = 1'b0;

  debounced_stepper_jog_driver uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .fwd_level    (fwd_level),
    .back_level   (back_level),
    .motor_enable (motor_enable),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coil_pattern (coil_pattern),
    .phase_index  (phase_index),
    .stepped      (stepped),
    .fwd_pressed  (fwd_pressed),
    .back_pressed (back_pressed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver pacing: random stall bursts, plus one long hold-off on request
  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!no_idle && rx_bursty && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : result_watch
    drive_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.coil    = coil_pattern;
        got.phase   = phase_index;
        got.stepped = stepped;
        got.fwd     = fwd_pressed;
        got.back    = back_pressed;
        tracker.match_result(got);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_tick(input logic fl, input logic bl, input logic en);
    if (!no_idle && tx_bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    fwd_level    <= fl;
    back_level   <= bl;
    motor_enable <= en;
    do @(posedge clk); while (in_stall);
    tracker.take_tick(fl, bl, en);
  endtask

  task automatic repeat_tick(input logic [2:0] levels, input int n);
    repeat (n) send_tick(levels[2], levels[1], levels[0]);
  endtask

  // drop valid and wait for every outstanding result before touching registers
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input logic [djd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [djd_pkg::REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // button runs: mostly one button held with random length, some noise
  task automatic run_phase(input int n_items, input int hold);
    int   sent;
    int   len;
    int   kind;
    int   i;
    logic fl;
    logic bl;
    logic en;
    sent = 0;
    while (sent < n_items) begin
      tx_bursty = ($urandom_range(0, 3) != 0);
      rx_bursty = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      fl   = !(kind <= 3 || kind == 7);
      bl   = !((kind >= 4 && kind <= 6) || kind == 7);
      en   = ($urandom_range(0, 4) != 0);
      len  = $urandom_range(1, hold);
      if (len > n_items - sent) len = n_items - sent;
      for (i = 0; i < len; i++) begin
        if (kind == 9) begin
          {fl, bl, en} = 3'($urandom);
        end else if ($urandom_range(0, 23) == 0) begin
          en = !en;
        end
        // contact bounce on the leading edge of a run
        if (kind != 9 && i < 3 && $urandom_range(0, 2) == 0) begin
          send_tick(!fl, bl, en);
        end else begin
          send_tick(fl, bl, en);
        end
        sent++;
      end
    end
  endtask

  task automatic jog_phase(input logic [djd_pkg::REG_W-1:0] deb,
                           input logic [djd_pkg::REG_W-1:0] intv, input int n_items);
    int hold;
    settle_idle();
    set_reg(djd_pkg::REG_DEBOUNCE, deb);
    set_reg(djd_pkg::REG_STEP_INTERVAL, intv);
    hold = int'(deb) + 4 * ((intv > 8) ? 8 : int'(intv)) + 8;
    if (hold > 1100) hold = 1100;
    run_phase(n_items, hold);
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first tick released, then forward goes low
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    settle_idle();
    set_reg(REG_SPARE_2, REG_TOP);
    set_reg(djd_pkg::REG_DEBOUNCE, '0);
    set_reg(djd_pkg::REG_STEP_INTERVAL, '0);
    set_reg(REG_SPARE_3, 10'd1);
    // zero debounce and interval: a held button steps on every tick after its first
    repeat_tick(3'b011, 4);
    repeat_tick(3'b101, 4);
    repeat_tick(3'b001, 2);
    repeat_tick(3'b010, 2);
    repeat_tick(3'b110, 1);
    repeat_tick(3'b100, 1);
    repeat_tick(3'b111, 2);
    repeat_tick(3'b011, 3);
    repeat_tick(3'b000, 1);

    jog_phase(10'd1, 10'd1, 120);
    jog_phase(djd_pkg::DEBOUNCE_RESET, djd_pkg::STEP_INTERVAL_RESET, 50);
    // long receiver hold-off while ticks keep coming
    hold_off_req = 1'b1;
    run_phase(130, 46);
    jog_phase('0, REG_TOP, 100);
    jog_phase(REG_TOP, '0, 100);
    repeat (4) jog_phase(10'($urandom_range(0, 15)), 10'($urandom_range(0, 6)), 60);

    // long hold at the largest settings, no idling from here
    settle_idle();
    no_idle = 1'b1;
    set_reg(djd_pkg::REG_DEBOUNCE, REG_TOP);
    set_reg(djd_pkg::REG_STEP_INTERVAL, REG_TOP);
    repeat_tick(3'b010, 250);
    repeat_tick(3'b011, 20);
    repeat_tick(3'b101, 10);

    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== debounced_stepper_jog_driver.f =====
design/djd_pkg.sv
design/djd_debounce.sv
design/debounced_stepper_jog_driver.sv
tb/sv/tb_debounced_stepper_jog_driver.sv
